// File: rtl/ppd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_pkg: shared types and constants of the priority process dispatcher
// Beat formats, opcode and status codes, register indexes and the records
// that pass between the controller and the row of task cells.
// ----------------------------------------------------------------------------
package ppd_pkg;

   localparam int TableDepth = 16;
   localparam int IdxW       = $clog2(TableDepth);
   localparam int CntW       = $clog2(TableDepth + 1);

   typedef enum logic [1:0] {
      OpAdd      = 2'd0,
      OpDispatch = 2'd1,
      OpReload   = 2'd2,
      OpClear    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      StatAdded    = 3'd0,
      StatFull     = 3'd1,
      StatRan      = 3'd2,
      StatNone     = 3'd3,
      StatReloaded = 3'd4,
      StatCleared  = 3'd5
   } status_type;

   localparam logic [1:0] CsrSelectShortest = 2'd0;
   localparam logic [1:0] CsrRunToCompl     = 2'd1;
   localparam logic [1:0] CsrTimeQuantum    = 2'd2;

   localparam logic [7:0] QuantumReset = 8'd4;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] task_id;
      logic [7:0]  task_priority;
      logic [15:0] burst_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] chosen_id;
      logic [31:0] start_time;
      logic [15:0] run_length;
      logic [15:0] left_after;
      logic        finished;
   } rsp_type;

   // best candidate so far, handed from cell to cell
   typedef struct packed {
      logic            found;
      logic [15:0]     key;
      logic [IdxW-1:0] idx;
      logic [15:0]     id;
      logic [15:0]     remaining;
   } cand_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic            add_valid;
      logic [IdxW-1:0] add_idx;
      logic [15:0]     add_id;
      logic [7:0]      add_priority;
      logic [15:0]     add_burst;
      logic            reload;
      logic            upd_valid;
      logic [IdxW-1:0] upd_idx;
      logic [15:0]     upd_left;
      logic            select_shortest;
      logic [CntW-1:0] count;
   } cell_ctrl_type;

endpackage

// File: rtl/ppd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_cell: one task table entry with its compare stage
// Holds id, priority, burst and remaining time of one slot, and passes the
// better of its own entry and the incoming candidate to the next cell.
// ----------------------------------------------------------------------------
module ppd_cell import ppd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic [IdxW-1:0] cell_idx,
   input  cell_ctrl_type   ctrl,
   input  cand_type        cand_prev,
   output cand_type        cand_next
);

   logic [15:0] id_ff;
   logic [7:0]  prio_ff;
   logic [15:0] burst_ff;
   logic [15:0] rem_ff;
   cand_type    cand_ff;
   cand_type    cand_in;

   logic        eligible;
   logic [15:0] my_key;

   assign my_key   = ctrl.select_shortest ? burst_ff : {8'd0, prio_ff};
   assign eligible = ({1'b0, cell_idx} < ctrl.count) && (rem_ff != 16'd0);

   // take own entry only on a strictly smaller key: earlier index wins a tie
   always_comb begin
      cand_in = cand_prev;
      if (eligible && (!cand_prev.found || my_key < cand_prev.key)) begin
         cand_in.found     = 1'b1;
         cand_in.key       = my_key;
         cand_in.idx       = cell_idx;
         cand_in.id        = id_ff;
         cand_in.remaining = rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.add_valid && ctrl.add_idx == cell_idx) begin
         id_ff    <= ctrl.add_id;
         prio_ff  <= ctrl.add_priority;
         burst_ff <= ctrl.add_burst;
         rem_ff   <= ctrl.add_burst;
      end else if (ctrl.reload) begin
         rem_ff <= burst_ff;
      end else if (ctrl.upd_valid && ctrl.upd_idx == cell_idx) begin
         rem_ff <= ctrl.upd_left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff.found <= 1'b0;
      end else begin
         cand_ff.found <= cand_in.found;
      end
      cand_ff.key       <= cand_in.key;
      cand_ff.idx       <= cand_in.idx;
      cand_ff.id        <= cand_in.id;
      cand_ff.remaining <= cand_in.remaining;
   end

   assign cand_next = cand_ff;

endmodule

// File: rtl/priority_process_dispatcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_process_dispatcher: task table with priority dispatch and quantum
// Add, dispatch, reload and clear beats against a row of task cells.
// ----------------------------------------------------------------------------
// Timing: add, reload and clear answer in the cycle after acceptance.
// Dispatch: the candidate walks the row of cells through each cell's register,
// then the finish state settles the run once the result slot is free.
// Requests: one item at a time; none is taken while a dispatch is in flight.
// Reset: synchronous, clears entry count, time counter, registers and control.
// ----------------------------------------------------------------------------
module priority_process_dispatcher import ppd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   typedef enum logic [1:0] {
      StIdle,
      StScan,
      StFinish
   } state_type;

   state_type       state_ff, state_in;
   logic [IdxW-1:0] scan_cnt_ff, scan_cnt_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [31:0]     time_ff, time_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   // configuration registers
   logic            sel_short_ff;
   logic            run_compl_ff;
   logic [7:0]      quantum_ff;

   cell_ctrl_type   ctrl;
   cand_type        chain [TableDepth+1];
   cand_type        best;

   logic            take_req;
   logic            slot_free;
   logic [15:0]     quantum_eff;
   logic [15:0]     run_len;
   logic [15:0]     left_len;

   // config port: always ready, writes land only while idle by contract
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_short_ff <= 1'b0;
         run_compl_ff <= 1'b0;
         quantum_ff   <= QuantumReset;
      end else if (csr_valid) begin
         case (csr_index)
            CsrSelectShortest: sel_short_ff <= csr_data[0];
            CsrRunToCompl:     run_compl_ff <= csr_data[0];
            CsrTimeQuantum:    quantum_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // an item is taken only in idle and only when the result slot is free
   // or frees up this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == StIdle && slot_free);
   assign take_req  = req_valid && !req_stall;

   // row of cells: the empty candidate enters at the head every cycle
   assign chain[0] = '0;

   for (genvar gi = 0; gi < TableDepth; gi++) begin : g_cell
      ppd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IdxW'(gi)),
         .ctrl      (ctrl),
         .cand_prev (chain[gi]),
         .cand_next (chain[gi+1])
      );
   end

   assign best = chain[TableDepth];

   // run length: zero quantum counts as one
   assign quantum_eff = (quantum_ff == 8'd0) ? 16'd1 : {8'd0, quantum_ff};
   assign run_len     = run_compl_ff ? best.remaining :
                        ((best.remaining < quantum_eff) ? best.remaining : quantum_eff);
   assign left_len    = best.remaining - run_len;

   always_comb begin
      state_in     = state_ff;
      scan_cnt_in  = scan_cnt_ff;
      count_in     = count_ff;
      time_in      = time_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      ctrl                 = '0;
      ctrl.add_idx         = count_ff[IdxW-1:0];
      ctrl.add_id          = req_data.task_id;
      ctrl.add_priority    = req_data.task_priority;
      ctrl.add_burst       = req_data.burst_length;
      ctrl.upd_idx         = best.idx;
      ctrl.upd_left        = left_len;
      ctrl.select_shortest = sel_short_ff;
      ctrl.count           = count_ff;

      case (state_ff)
         StIdle: begin
            if (take_req) begin
               rsp_data_in = '0;
               case (req_data.opcode)
                  OpAdd: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CntW'(TableDepth)) begin
                        rsp_data_in.status = StatFull;
                     end else begin
                        ctrl.add_valid     = 1'b1;
                        count_in           = count_ff + CntW'(1);
                        rsp_data_in.status = StatAdded;
                     end
                  end
                  OpDispatch: begin
                     // hold table steady while the candidate walks the row
                     state_in    = StScan;
                     scan_cnt_in = '0;
                  end
                  OpReload: begin
                     ctrl.reload        = 1'b1;
                     rsp_valid_in       = 1'b1;
                     rsp_data_in.status = StatReloaded;
                  end
                  OpClear: begin
                     count_in           = '0;
                     time_in            = '0;
                     rsp_valid_in       = 1'b1;
                     rsp_data_in.status = StatCleared;
                  end
                  default: ;
               endcase
            end
         end
         StScan: begin
            scan_cnt_in = scan_cnt_ff + IdxW'(1);
            if (scan_cnt_ff == IdxW'(TableDepth - 1)) begin
               state_in = StFinish;
            end
         end
         StFinish: begin
            if (slot_free) begin
               state_in     = StIdle;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (!best.found) begin
                  rsp_data_in.status = StatNone;
               end else begin
                  // write back remaining time and advance the clock
                  ctrl.upd_valid         = 1'b1;
                  rsp_data_in.status     = StatRan;
                  rsp_data_in.chosen_id  = best.id;
                  rsp_data_in.start_time = time_ff;
                  rsp_data_in.run_length = run_len;
                  rsp_data_in.left_after = left_len;
                  rsp_data_in.finished   = (left_len == 16'd0);
                  time_in                = time_ff + {16'd0, run_len};
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         scan_cnt_ff  <= '0;
         count_ff     <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         count_ff     <= count_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   // a dispatch beat blocks further requests while the scan runs
   assert property (@(posedge clock) disable iff (reset)
      (take_req && req_data.opcode == OpDispatch) |=> (state_ff == StScan && req_stall))
      else $error("dispatch did not start a scan");

   // finished flag agrees with the remaining time reported
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == StatRan) |->
         (rsp_data.finished == (rsp_data.left_after == 16'd0)))
      else $error("finished flag inconsistent with left_after");

   // results other than a run carry zero payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != StatRan) |->
         (rsp_data.chosen_id == 16'd0 && rsp_data.start_time == 32'd0 &&
          rsp_data.run_length == 16'd0))
      else $error("payload not zero on non-run status");

   // the entry count never runs past the table
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(TableDepth))
      else $error("entry count beyond table depth");

endmodule

// File: dv/priority_process_dispatcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_process_dispatcher_tb: self-checking bench for the task dispatcher
// Streams add, dispatch, reload and clear beats into the block under random
// idling on both channels. Every accepted request beat is run through a local
// scheduler model at acceptance, and every result beat is checked field by
// field against the oldest predicted result. Runs across several register
// settings, including both selection rules, slicing on and off and the
// quantum extremes, with one long result-side hold to back the block up.
// ----------------------------------------------------------------------------
module priority_process_dispatcher_tb;
   import ppd_pkg::*;

   localparam int PhaseItems  = 108;
   localparam int PhaseCount  = 8;
   localparam int DrainCycles = 2 * TableDepth;
   localparam int HoldCycles  = 400;
   localparam int MaxReports  = 200;

   // index with no register behind it; writes there must change nothing
   localparam logic [1:0] CsrUnmapped = 2'd3;

   logic       clock;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_data  = '0;

   priority_process_dispatcher u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Scheduler model: task table, time counter and register copies
   // ---------------------------------------------------------------------
   logic [15:0] tbl_id    [TableDepth];
   logic [7:0]  tbl_prio  [TableDepth];
   logic [15:0] tbl_burst [TableDepth];
   logic [15:0] tbl_left  [TableDepth];
   int unsigned tbl_count;
   logic [31:0] clock_units;
   logic        cfg_shortest;
   logic        cfg_complete;
   logic [7:0]  cfg_quantum;

   req_type     pending_cmds[$];   // request beats not yet offered
   rsp_type     due_results[$];    // predicted result beats, oldest first
   int unsigned cmds_queued  = 0;
   int unsigned results_seen = 0;
   int unsigned fail_count   = 0;

   int unsigned send_gap  = 0;
   logic        send_idle = 1'b1;
   int unsigned recv_gap  = 0;
   logic        recv_idle = 1'b1;
   int unsigned hold_left = 0;
   logic        long_hold = 1'b0;
   logic        hold_kick = 1'b0;

   // Apply one request beat to the model table and return the result it earns.
   function automatic rsp_type schedule_outcome(input req_type beat);
      rsp_type     res;
      logic        found;
      int          best;
      logic [15:0] key;
      logic [15:0] best_key;
      logic [15:0] rem;
      logic [15:0] slice;
      logic [15:0] run;
      res      = '0;
      found    = 1'b0;
      best     = 0;
      best_key = '0;
      case (beat.opcode)
         OpAdd: begin
            if (tbl_count >= TableDepth) begin
               res.status = StatFull;
            end else begin
               tbl_id[tbl_count]    = beat.task_id;
               tbl_prio[tbl_count]  = beat.task_priority;
               tbl_burst[tbl_count] = beat.burst_length;
               tbl_left[tbl_count]  = beat.burst_length;
               tbl_count++;
               res.status = StatAdded;
            end
         end
         OpDispatch: begin
            // scan valid entries in index order; strict less-than keeps the
            // lowest index on a tie, and drained entries are skipped
            for (int i = 0; i < tbl_count; i++) begin
               if (tbl_left[i] != 16'd0) begin
                  key = cfg_shortest ? tbl_burst[i] : {8'd0, tbl_prio[i]};
                  if (!found || key < best_key) begin
                     found    = 1'b1;
                     best_key = key;
                     best     = i;
                  end
               end
            end
            if (!found) begin
               res.status = StatNone;
            end else begin
               rem   = tbl_left[best];
               // a zero quantum still grants one unit
               slice = (cfg_quantum == 8'd0) ? 16'd1 : {8'd0, cfg_quantum};
               run   = cfg_complete ? rem : ((rem < slice) ? rem : slice);
               tbl_left[best]  = rem - run;
               res.status      = StatRan;
               res.chosen_id   = tbl_id[best];
               res.start_time  = clock_units;
               res.run_length  = run;
               res.left_after  = rem - run;
               res.finished    = (rem == run);
               clock_units     = clock_units + {16'd0, run};
            end
         end
         OpReload: begin
            for (int i = 0; i < tbl_count; i++) begin
               tbl_left[i] = tbl_burst[i];
            end
            res.status = StatReloaded;
         end
         default: begin
            // clear drops the entries and the time counter, stores keep data
            tbl_count   = 0;
            clock_units = '0;
            res.status  = StatCleared;
         end
      endcase
      return res;
   endfunction

   function automatic void enqueue_cmd(input op_type op, input logic [15:0] id,
                                       input logic [7:0] prio, input logic [15:0] burst);
      req_type beat;
      beat.opcode        = op;
      beat.task_id       = id;
      beat.task_priority = prio;
      beat.burst_length  = burst;
      pending_cmds.push_back(beat);
      cmds_queued++;
   endfunction

   // Queue a beat whose data fields carry random filler.
   function automatic void enqueue_noise(input op_type op);
      enqueue_cmd(op, 16'($urandom), 8'($urandom), 16'($urandom));
   endfunction

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= MaxReports)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: offer queued beats, predict each one as it is taken
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_proc
      logic    next_valid;
      req_type next_beat;
      next_valid = req_valid;
      next_beat  = req_data;
      if (reset) begin
         next_valid   = 1'b0;
         send_gap     = 0;
         tbl_count    = 0;
         clock_units  = '0;
         cfg_shortest = 1'b0;
         cfg_complete = 1'b0;
         cfg_quantum  = QuantumReset;
      end else begin
         if (req_valid && !req_stall) begin
            due_results.push_back(schedule_outcome(req_data));
            next_valid = 1'b0;
            // flip idling now and then so long back-to-back runs occur too
            if ($urandom_range(0, 31) == 0)
               send_idle = !send_idle;
            send_gap = send_idle ? $urandom_range(0, 3) : 0;
         end
         // compute the next valid once so a held valid is never dropped and raised
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_cmds.size() != 0) begin
               next_valid = 1'b1;
               next_beat  = pending_cmds.pop_front();
            end
         end
      end
      req_valid <= next_valid;
      req_data  <= next_beat;
   end

   // ---------------------------------------------------------------------
   // Result monitor: drive stall, check each taken beat against the oldest
   // prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_proc
      rsp_type want;
      if (reset) begin
         recv_gap = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (due_results.size() == 0) begin
               fail_count++;
               if (fail_count <= MaxReports)
                  $display("%0t: result beat with nothing expected, expected none, got %p",
                           $time, rsp_data);
            end else begin
               want = due_results.pop_front();
               check_field("status",     32'(want.status),     32'(rsp_data.status));
               check_field("chosen_id",  32'(want.chosen_id),  32'(rsp_data.chosen_id));
               check_field("start_time", want.start_time,      rsp_data.start_time);
               check_field("run_length", 32'(want.run_length), 32'(rsp_data.run_length));
               check_field("left_after", 32'(want.left_after), 32'(rsp_data.left_after));
               check_field("finished",   32'(want.finished),   32'(rsp_data.finished));
            end
            if ($urandom_range(0, 31) == 0)
               recv_idle = !recv_idle;
            recv_gap = recv_idle ? $urandom_range(0, 3) : 0;
         end else if (recv_gap > 0) begin
            recv_gap--;
         end
         rsp_stall <= (recv_gap > 0) || long_hold;
      end
   end

   // Long result-side hold: count it out here so the block backs up and
   // stalls its request side while the driver keeps offering.
   always @(posedge clock) begin : hold_proc
      if (reset) begin
         hold_left = 0;
         long_hold <= 1'b0;
      end else begin
         if (hold_kick)
            hold_left = HoldCycles;
         else if (hold_left > 0)
            hold_left--;
         long_hold <= (hold_left > 0);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and phase control
   // ---------------------------------------------------------------------

   // Block until every queued beat has come back as a result.
   task automatic wait_idle();
      do @(posedge clock);
      while (results_seen < cmds_queued);
   endtask

   // Call at a rising edge; leaves csr_valid high for a following write.
   task automatic write_register(input logic [1:0] index, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      case (index)
         CsrSelectShortest: cfg_shortest = value[0];
         CsrRunToCompl:     cfg_complete = value[0];
         CsrTimeQuantum:    cfg_quantum  = value;
         default: ;
      endcase
   endtask

   task automatic queue_directed();
      // empty table: dispatch finds nothing, reload touches nothing
      enqueue_noise(OpDispatch);
      enqueue_noise(OpReload);
      // zero burst task is stored but never ready
      enqueue_cmd(OpAdd, 16'hFFFF, 8'hFF, 16'h0000);
      enqueue_noise(OpDispatch);
      // equal priorities: the lower index must win
      enqueue_cmd(OpAdd, 16'h0000, 8'h00, 16'hFFFF);
      enqueue_cmd(OpAdd, 16'h5A5A, 8'h00, 16'h0003);
      enqueue_noise(OpDispatch);
      // fill the table, then one more add reports full
      repeat (TableDepth - 3)
         enqueue_cmd(OpAdd, 16'($urandom), 8'($urandom), 16'($urandom_range(1, 9)));
      enqueue_cmd(OpAdd, 16'hA5A5, 8'h01, 16'h0001);
      enqueue_noise(OpDispatch);
      enqueue_noise(OpReload);
      enqueue_noise(OpDispatch);
      // clear: table empties and time restarts from zero
      enqueue_noise(OpClear);
      enqueue_noise(OpDispatch);
   endtask

   // Mostly fill-then-drain sequences with random content, some raw noise.
   task automatic queue_random(input int unsigned count);
      int unsigned first;
      int unsigned adds;
      int unsigned runs;
      logic [7:0]  prio;
      logic [15:0] burst;
      first = cmds_queued;
      while (cmds_queued - first < count) begin
         if ($urandom_range(0, 9) < 7) begin
            // skip the clear now and then so adds pile up into a full table
            if ($urandom_range(0, 3) != 0)
               enqueue_noise(OpClear);
            adds = $urandom_range(1, TableDepth + 2);
            repeat (adds) begin
               // narrow priorities half the time to force ties
               prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                           : 8'($urandom_range(0, 255));
               case ($urandom_range(0, 15))
                  0:       burst = 16'd0;
                  1:       burst = 16'($urandom_range(0, 65535));
                  default: burst = 16'($urandom_range(1, 12));
               endcase
               enqueue_cmd(OpAdd, 16'($urandom), prio, burst);
            end
            runs = $urandom_range(4, 48);
            repeat (runs) begin
               case ($urandom_range(0, 15))
                  0:       enqueue_noise(OpReload);
                  1:       enqueue_cmd(OpAdd, 16'($urandom), 8'($urandom),
                                       16'($urandom_range(1, 12)));
                  default: enqueue_noise(OpDispatch);
               endcase
            end
         end else begin
            repeat ($urandom_range(1, 8))
               enqueue_noise(op_type'($urandom_range(0, 3)));
         end
      end
   endtask

   initial begin : run_proc
      int unsigned round;
      logic        sel;
      logic        full_run;
      logic [7:0]  quantum;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      queue_directed();
      for (round = 0; round < PhaseCount; round++) begin
         wait_idle();
         // settings walk both selection rules, slicing on/off, quantum extremes
         case (round)
            0:       begin sel = 1'b1; full_run = 1'b0; quantum = 8'd1;   end
            1:       begin sel = 1'b0; full_run = 1'b1; quantum = 8'd255; end
            2:       begin sel = 1'b0; full_run = 1'b0; quantum = 8'd0;   end
            3:       begin sel = 1'b1; full_run = 1'b1; quantum = 8'd255; end
            4:       begin sel = 1'b0; full_run = 1'b0; quantum = 8'd255; end
            default: begin
               sel      = 1'($urandom_range(0, 1));
               full_run = 1'($urandom_range(0, 1));
               quantum  = 8'($urandom_range(0, 255));
            end
         endcase
         // upper data bits of the one-bit registers are don't-care; toggle them
         write_register(CsrSelectShortest, {7'($urandom), sel});
         write_register(CsrRunToCompl, {7'($urandom), full_run});
         write_register(CsrTimeQuantum, quantum);
         if (round == 5)
            write_register(CsrUnmapped, 8'($urandom));
         csr_valid <= 1'b0;
         if (round == 4) begin
            hold_kick <= 1'b1;
            @(posedge clock);
            hold_kick <= 1'b0;
         end
         @(negedge clock);
         queue_random(PhaseItems);
      end
      wait_idle();
      repeat (DrainCycles) @(posedge clock);
      if (due_results.size() != 0) begin
         fail_count++;
         $display("%0t: %0d predicted result beats never arrived", $time,
                  due_results.size());
      end
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of this stimulus.
   initial begin : watchdog_proc
      #(5_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
